// ===== sv/mcqd_pkg.sv =====
// Package for the multi-channel quadrature decoder.
// Holds operation codes, field widths and the x4 transition step table.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mcqd_pkg;

	localparam int OP_W    = 2;
	localparam int CHAN_W  = 2;
	localparam int PHASE_W = 2;
	localparam int POS_W   = 32;

	localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
	localparam logic [OP_W-1:0] OP_RESET_ONE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET_ALL = 2'd2;

	typedef logic signed [1:0] step_t;

	// Indexed by {previous phase, current phase}, a phase being {B, A}.
	localparam step_t STEP_TABLE [16] = '{
		2'sb00, 2'sb01, 2'sb11, 2'sb00,
		2'sb11, 2'sb00, 2'sb00, 2'sb01,
		2'sb01, 2'sb00, 2'sb00, 2'sb11,
		2'sb00, 2'sb11, 2'sb01, 2'sb00
	};

endpackage
`default_nettype wire

// ===== sv/mcqd_in_if.sv =====
// Input channel of the quadrature decoder: valid/ready and one item beat.
// Depends on mcqd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mcqd_in_if;
	logic                        valid;
	logic                        ready;
	logic [mcqd_pkg::OP_W-1:0]   operation;
	logic [mcqd_pkg::CHAN_W-1:0] channel;
	logic                        phase_a;
	logic                        phase_b;

	modport source (output valid, operation, channel, phase_a, phase_b, input ready);
	modport sink   (input valid, operation, channel, phase_a, phase_b, output ready);
endinterface
`default_nettype wire

// ===== sv/mcqd_out_if.sv =====
// Result channel of the quadrature decoder: valid/ready and one result beat.
// Depends on mcqd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mcqd_out_if;
	logic                              valid;
	logic                              ready;
	logic [mcqd_pkg::CHAN_W-1:0]       channel_out;
	logic signed [mcqd_pkg::POS_W-1:0] position;

	modport source (output valid, channel_out, position, input ready);
	modport sink   (input valid, channel_out, position, output ready);
endinterface
`default_nettype wire

// ===== sv/mcqd_state_mem.sv =====
// Per-channel state memory: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mcqd_state_mem #(
	parameter int DEPTH  = 4,
	parameter int ADDR_W = 2,
	parameter int DATA_W = 34
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/multi_channel_quadrature_decoder_top.sv =====
// A result beat moves from the stage 1 registers to the output register, held while stalled.
// Throughput: one item per cycle while the output is not stalled; the state memory is read on
// accept, then updated and written back from stage 1, the last write forwarded to the next item.
// Reset clears per-channel valid flags, so every phase and count reads as zero at once;
// there is no clearing pass. A reset-all item clears all the count flags together.
// Depends on mcqd_pkg, mcqd_in_if, mcqd_out_if and mcqd_state_mem.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_quadrature_decoder_top #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mcqd_in_if.sink     items,
	mcqd_out_if.source  results
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int ENT_W = COUNT_WIDTH + mcqd_pkg::PHASE_W;

	logic in_acc;
	logic out_free;
	logic s1_adv;

	logic                           valid_s1;
	logic [mcqd_pkg::OP_W-1:0]      op_s1;
	logic [mcqd_pkg::CHAN_W-1:0]    chan_s1;
	logic [CH_W-1:0]                idx_s1;
	logic [mcqd_pkg::PHASE_W-1:0]   phase_s1;
	logic                           present_s1;

	logic [ENT_W-1:0]               rd_data;
	logic [ENT_W-1:0]               wr_data;
	logic                           wr_en;

	logic [NUM_CHANNELS-1:0]        ph_vld_q;
	logic [NUM_CHANNELS-1:0]        cnt_vld_q;

	logic                           byp_valid_q;
	logic [CH_W-1:0]                byp_idx_q;
	logic [mcqd_pkg::PHASE_W-1:0]   byp_phase_q;
	logic [COUNT_WIDTH-1:0]         byp_cnt_q;

	logic                           out_valid_q;
	logic [mcqd_pkg::CHAN_W-1:0]    out_chan_q;
	logic signed [mcqd_pkg::POS_W-1:0] out_pos_q;

	logic                           byp_hit;
	logic [mcqd_pkg::PHASE_W-1:0]   old_phase;
	logic [COUNT_WIDTH-1:0]         old_cnt;
	logic [mcqd_pkg::PHASE_W-1:0]   new_phase;
	logic signed [COUNT_WIDTH-1:0]  new_cnt;
	logic signed [COUNT_WIDTH-1:0]  step_ext;
	logic                           do_write;
	logic                           do_clear_all;
	logic signed [mcqd_pkg::POS_W-1:0] pos_next;

	assign out_free     = !out_valid_q || results.ready;
	assign s1_adv       = valid_s1 && out_free;
	assign items.ready  = !valid_s1 || out_free;
	assign in_acc       = items.valid && items.ready;

	mcqd_state_mem #(
		.DEPTH  (NUM_CHANNELS),
		.ADDR_W (CH_W),
		.DATA_W (ENT_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (CH_W'(items.channel)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= items.operation;
			chan_s1    <= items.channel;
			idx_s1     <= CH_W'(items.channel);
			phase_s1   <= {items.phase_b, items.phase_a};
			present_s1 <= (32'(items.channel) < NUM_CHANNELS);
		end
	end

	always_comb begin
		byp_hit   = byp_valid_q && (byp_idx_q == idx_s1);
		old_phase = '0;
		old_cnt   = '0;
		if (byp_hit) begin
			old_phase = byp_phase_q;
			old_cnt   = byp_cnt_q;
		end else if (present_s1) begin
			if (ph_vld_q[idx_s1]) begin
				old_phase = rd_data[ENT_W-1 -: mcqd_pkg::PHASE_W];
			end
			if (cnt_vld_q[idx_s1]) begin
				old_cnt = rd_data[COUNT_WIDTH-1:0];
			end
		end
		step_ext     = COUNT_WIDTH'(mcqd_pkg::STEP_TABLE[{old_phase, phase_s1}]);
		new_phase    = old_phase;
		new_cnt      = old_cnt;
		do_write     = 1'b0;
		do_clear_all = 1'b0;
		case (op_s1)
			mcqd_pkg::OP_SAMPLE: begin
				new_phase = phase_s1;
				new_cnt   = old_cnt + step_ext;
				do_write  = present_s1;
			end
			mcqd_pkg::OP_RESET_ONE: begin
				new_cnt  = '0;
				do_write = present_s1;
			end
			mcqd_pkg::OP_RESET_ALL: begin
				new_cnt      = '0;
				do_clear_all = 1'b1;
			end
			default: begin
				new_cnt = old_cnt;
			end
		endcase
		pos_next = present_s1 ? mcqd_pkg::POS_W'(new_cnt) : '0;
	end

	assign wr_en   = s1_adv && do_write;
	assign wr_data = {new_phase, new_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_vld_q    <= '0;
			cnt_vld_q   <= '0;
			byp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			if (do_clear_all) begin
				cnt_vld_q   <= '0;
				byp_valid_q <= 1'b0;
			end else if (do_write) begin
				ph_vld_q[idx_s1]  <= 1'b1;
				cnt_vld_q[idx_s1] <= 1'b1;
				byp_valid_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_idx_q   <= idx_s1;
			byp_phase_q <= new_phase;
			byp_cnt_q   <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_chan_q <= chan_s1;
			out_pos_q  <= pos_next;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.channel_out = out_chan_q;
	assign results.position    = out_pos_q;

endmodule
`default_nettype wire

// ===== sv/mcqd_checker.sv =====
// Port-level checks for the quadrature decoder, attached to the top level by bind.
// Depends on mcqd_pkg and multi_channel_quadrature_decoder_top.
`timescale 1ns / 1ps
`default_nettype none
module mcqd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [mcqd_pkg::OP_W-1:0]         in_operation,
	input wire logic [mcqd_pkg::CHAN_W-1:0]       in_channel,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [mcqd_pkg::CHAN_W-1:0]       out_channel,
	input wire logic signed [mcqd_pkg::POS_W-1:0] out_position
);

	logic in_acc;
	logic is_reset_op;

	assign in_acc      = in_valid && in_ready;
	assign is_reset_op = (in_operation == mcqd_pkg::OP_RESET_ONE) ||
		(in_operation == mcqd_pkg::OP_RESET_ALL);

	// A stalled result beat holds its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_position))
		else $error("result beat changed while stalled");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result beat withdrawn without being taken");

	// A reset beat that meets an open result path reports a zero count for its channel.
	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_reset_op ##1 out_ready |=>
			out_valid && (out_position == '0) && (out_channel == $past(in_channel, 2)))
		else $error("reset beat did not report a cleared count");

	// With the result path open, an accepted beat passes stage 1 and is presented on the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 out_ready |=> out_valid)
		else $error("accepted beat not presented on time");

endmodule

bind multi_channel_quadrature_decoder_top mcqd_checker u_mcqd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_operation (items.operation),
	.in_channel   (items.channel),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_channel  (results.channel_out),
	.out_position (results.position)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for multi_channel_quadrature_decoder_top: it drives item beats
// and checks every result beat against a position tracker kept inside the bench.
// Depends on mcqd_pkg, mcqd_in_if, mcqd_out_if and the decoder RTL.
`timescale 1ns / 1ps
module tb_top;

	localparam int NUM_CH       = 4;
	localparam int RANDOM_ITEMS = 1800;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int HOLD_CYCLES  = 200;
	localparam logic [mcqd_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;

	typedef struct {
		logic [mcqd_pkg::CHAN_W-1:0]       channel;
		logic signed [mcqd_pkg::POS_W-1:0] position;
	} position_report_t;

	class position_tracker;
		logic [mcqd_pkg::PHASE_W-1:0] last_phase [NUM_CH];
		logic [mcqd_pkg::POS_W-1:0]   count [NUM_CH];
		position_report_t             expected_positions [$];
		int                           errors;

		function new();
			foreach (count[i]) begin
				count[i] = '0;
				last_phase[i] = '0;
			end
			errors = 0;
		endfunction

		function void note_item(logic [mcqd_pkg::OP_W-1:0] op,
				logic [mcqd_pkg::CHAN_W-1:0] ch, logic a, logic b);
			logic [mcqd_pkg::PHASE_W-1:0] cur;
			logic [1:0]                   rank_step;
			position_report_t             report;
			cur = {b, a};
			case (op)
				mcqd_pkg::OP_SAMPLE: begin
					// A phase's place on the Gray cycle is {B, A xor B}.
					rank_step = {cur[1], cur[1] ^ cur[0]}
						- {last_phase[ch][1], last_phase[ch][1] ^ last_phase[ch][0]};
					if (rank_step == 2'd1)
						count[ch] = count[ch] + 1'b1;
					else if (rank_step == 2'd3)
						count[ch] = count[ch] - 1'b1;
					last_phase[ch] = cur;
				end
				mcqd_pkg::OP_RESET_ONE: count[ch] = '0;
				mcqd_pkg::OP_RESET_ALL: begin
					foreach (count[i])
						count[i] = '0;
				end
				default: ;
			endcase
			report.channel = ch;
			report.position = count[ch];
			expected_positions.push_back(report);
		endfunction

		function void check_result(logic [mcqd_pkg::CHAN_W-1:0] ch,
				logic signed [mcqd_pkg::POS_W-1:0] pos);
			position_report_t report;
			if (expected_positions.size() == 0) begin
				$error("Result beat with no item outstanding: channel_out %0d position %0d",
					ch, pos);
				errors++;
				return;
			end
			report = expected_positions.pop_front();
			if (ch !== report.channel) begin
				$error("channel_out mismatch: expected %0d, actual %0d", report.channel, ch);
				errors++;
			end
			if (pos !== report.position) begin
				$error("position mismatch: expected %0d, actual %0d", report.position, pos);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mcqd_in_if  in_bus ();
	mcqd_out_if out_bus ();

	position_tracker              tracker;
	logic [mcqd_pkg::PHASE_W-1:0] sent_phase [NUM_CH];
	bit                           walk_up [NUM_CH];
	int                           stall_mode = 0;
	bit                           hold_request = 1'b0;
	int                           cycle_count = 0;

	multi_channel_quadrature_decoder_top #(
		.NUM_CHANNELS(NUM_CH),
		.COUNT_WIDTH (mcqd_pkg::POS_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (in_bus),
		.results(out_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready)
			tracker.check_result(out_bus.channel_out, out_bus.position);
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The receiver stalls at random when stall mode is on, or for a long stretch when one is requested.
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left--;
			end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
				stall_left = idle_length();
				out_bus.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [mcqd_pkg::OP_W-1:0] op,
			input logic [mcqd_pkg::CHAN_W-1:0] ch, input logic a, input logic b);
		@(negedge clk);
		in_bus.valid <= 1'b1;
		in_bus.operation <= op;
		in_bus.channel <= ch;
		in_bus.phase_a <= a;
		in_bus.phase_b <= b;
		do
			@(posedge clk);
		while (!in_bus.ready);
		tracker.note_item(op, ch, a, b);
		if (op == mcqd_pkg::OP_SAMPLE)
			sent_phase[ch] = {b, a};
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_bus.valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (tracker.expected_positions.size() != 0)
			@(posedge clk);
	endtask

	// Mostly single Gray steps in a drifting direction, with some noise mixed in.
	task automatic send_random_item();
		logic [mcqd_pkg::CHAN_W-1:0]  ch;
		logic [mcqd_pkg::PHASE_W-1:0] next;
		logic [1:0]                   rank;
		int                           r;
		ch = mcqd_pkg::CHAN_W'($urandom_range(0, NUM_CH - 1));
		r = $urandom_range(0, 99);
		if (r < 75) begin
			if ($urandom_range(0, 9) == 0)
				walk_up[ch] = !walk_up[ch];
			rank = {sent_phase[ch][1], sent_phase[ch][1] ^ sent_phase[ch][0]};
			rank = walk_up[ch] ? rank + 1'b1 : rank - 1'b1;
			next = {rank[1], rank[1] ^ rank[0]};
			send_item(mcqd_pkg::OP_SAMPLE, ch, next[0], next[1]);
		end else if (r < 83) begin
			send_item(mcqd_pkg::OP_SAMPLE, ch, sent_phase[ch][0], sent_phase[ch][1]);
		end else if (r < 88) begin
			send_item(mcqd_pkg::OP_SAMPLE, ch, !sent_phase[ch][0], !sent_phase[ch][1]);
		end else if (r < 94) begin
			send_item(mcqd_pkg::OP_RESET_ONE, ch, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (r < 97) begin
			send_item(mcqd_pkg::OP_RESET_ALL, ch, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else begin
			send_item(OP_UNDEFINED, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_random_phase(input int items, input int mode, input int hold_at);
		stall_mode = mode;
		for (int i = 0; i < items; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			if (stall_mode != 0)
				idle_sender(idle_length());
			send_random_item();
		end
		wait_for_results();
	endtask

	initial begin
		tracker = new();
		foreach (sent_phase[i]) begin
			sent_phase[i] = '0;
			walk_up[i] = 1'b1;
		end
		in_bus.valid = 1'b0;
		in_bus.operation = mcqd_pkg::OP_SAMPLE;
		in_bus.channel = '0;
		in_bus.phase_a = 1'b0;
		in_bus.phase_b = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Forward count on channel 0 and backward count on channel 1.
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b1, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b1, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b0, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b0, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b1, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd1, 1'b0, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd1, 1'b1, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd1, 1'b1, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd1, 1'b0, 1'b0);
		// Both lines changing at once and no change at all must leave the count alone.
		send_item(mcqd_pkg::OP_SAMPLE, 2'd2, 1'b1, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd2, 1'b1, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd2, 1'b0, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd2, 1'b1, 1'b0);
		send_item(OP_UNDEFINED, 2'd3, 1'b1, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd3, 1'b0, 1'b1);
		send_item(mcqd_pkg::OP_RESET_ONE, 2'd1, 1'b1, 1'b0);
		send_item(OP_UNDEFINED, 2'd0, 1'b0, 1'b0);
		send_item(mcqd_pkg::OP_RESET_ALL, 2'd3, 1'b0, 1'b1);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd0, 1'b0, 1'b0);
		send_item(mcqd_pkg::OP_SAMPLE, 2'd1, 1'b0, 1'b1);
		send_item(OP_UNDEFINED, 2'd2, 1'b1, 1'b1);
		wait_for_results();

		run_random_phase(RANDOM_ITEMS / 4, 0, -1);
		run_random_phase(RANDOM_ITEMS * 3 / 8, 1, 100);
		run_random_phase(RANDOM_ITEMS * 3 / 8, 1, 300);

		repeat (8) @(posedge clk);
		if (tracker.expected_positions.size() != 0) begin
			$error("%0d result beats never arrived", tracker.expected_positions.size());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
sv/mcqd_pkg.sv
sv/mcqd_in_if.sv
sv/mcqd_out_if.sv
sv/mcqd_state_mem.sv
sv/multi_channel_quadrature_decoder_top.sv
sv/mcqd_checker.sv
tb/tb_top.sv
